// ===== sv/tpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tpe_pkg;

   localparam int CoordWidth    = 6;
   localparam int DimWidth      = 7;
   localparam int ColorWidth    = 32;
   localparam int OffsetWidth   = 14;
   localparam int WordAddrWidth = 12;
   localparam int StoreWords    = 4096;
   localparam int CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CsrImageWidth  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrImageHeight = 2'd1;

   localparam logic [DimWidth-1:0] DimReset     = 7'd64;
   localparam logic [DimWidth-1:0] WidthInUse   = 7'h7C;

   localparam logic [1:0] FuncWrite  = 2'd0;
   localparam logic [1:0] FuncRead   = 2'd1;
   localparam logic [1:0] FuncInvert = 2'd2;
   localparam logic [1:0] FuncGray   = 2'd3;

   localparam logic [7:0] LumaRed   = 8'd77;
   localparam logic [7:0] LumaGreen = 8'd150;
   localparam logic [7:0] LumaBlue  = 8'd28;

   typedef struct packed {
      logic                     in_range;
      logic [OffsetWidth-1:0]   offset;
      logic [WordAddrWidth-1:0] word_addr;
   } addr_type;

endpackage

`default_nettype wire

// ===== sv/tpe_addr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tpe_addr (
   input  wire logic [tpe_pkg::CoordWidth-1:0] pixel_x,
   input  wire logic [tpe_pkg::CoordWidth-1:0] pixel_y,
   input  wire logic [tpe_pkg::DimWidth-1:0]   image_width,
   input  wire logic [tpe_pkg::DimWidth-1:0]   image_height,
   output tpe_pkg::addr_type                   addr
);

   logic [tpe_pkg::DimWidth-1:0]    width_used;
   logic [10:0]                     row_prod;
   logic [tpe_pkg::OffsetWidth-1:0] offset;
   logic                            in_range;

   always_comb begin
      width_used = image_width & tpe_pkg::WidthInUse;
      in_range   = ({1'b0, pixel_x} < width_used) && ({1'b0, pixel_y} < image_height);
      row_prod   = 11'(pixel_y[5:2]) * 11'(width_used);
      offset     = 14'({row_prod, 4'b0000})
                 + 14'({pixel_x[5:2], 6'b000000})
                 + 14'({pixel_y[1:0], pixel_x[1:0], 1'b0});

      // The four bytes of a pixel share one word: bits 5 and 0 are always clear
      addr.in_range  = in_range;
      addr.offset    = in_range ? offset : '0;
      addr.word_addr = {offset[13:6], offset[4:1]};
   end

endmodule

`default_nettype wire

// ===== sv/tpe_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tpe_store (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                rd_en,
   input  wire logic [tpe_pkg::WordAddrWidth-1:0]   rd_addr,
   input  wire logic                                wr_en,
   input  wire logic [tpe_pkg::WordAddrWidth-1:0]   wr_addr,
   input  wire logic [tpe_pkg::ColorWidth-1:0]      wr_data,
   output logic      [tpe_pkg::ColorWidth-1:0]      rd_data
);

   logic [tpe_pkg::ColorWidth-1:0]    mem [tpe_pkg::StoreWords];
   logic [tpe_pkg::ColorWidth-1:0]    mem_q_ff;
   logic [tpe_pkg::WordAddrWidth-1:0] rd_addr_ff;
   logic                              fwd_valid_ff;
   logic                              fwd_valid_in;
   logic [tpe_pkg::WordAddrWidth-1:0] fwd_addr_ff;
   logic [tpe_pkg::ColorWidth-1:0]    fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff   <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // last write, covers a read issued on the same edge
   assign fwd_valid_in = fwd_valid_ff | wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
      end
      if (wr_en) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = (fwd_valid_ff && (fwd_addr_ff == rd_addr_ff)) ? fwd_data_ff : mem_q_ff;

endmodule

`default_nettype wire

// ===== sv/tpe_modify.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tpe_modify (
   input  wire logic [1:0]                       func,
   input  wire logic [tpe_pkg::ColorWidth-1:0]   write_color,
   input  wire logic [tpe_pkg::ColorWidth-1:0]   stored_color,
   output logic      [tpe_pkg::ColorWidth-1:0]   new_color,
   output logic                                  writes_back
);

   logic [15:0] luma_sum;
   logic [7:0]  gray;

   always_comb begin
      luma_sum = 16'(stored_color[31:24]) * 16'(tpe_pkg::LumaRed)
               + 16'(stored_color[23:16]) * 16'(tpe_pkg::LumaGreen)
               + 16'(stored_color[15:8])  * 16'(tpe_pkg::LumaBlue);
      gray     = luma_sum[15:8];

      case (func)
         tpe_pkg::FuncWrite: begin
            new_color   = write_color;
            writes_back = 1'b1;
         end
         tpe_pkg::FuncRead: begin
            new_color   = stored_color;
            writes_back = 1'b0;
         end
         tpe_pkg::FuncInvert: begin
            new_color   = {~stored_color[31:8], stored_color[7:0]};
            writes_back = 1'b1;
         end
         tpe_pkg::FuncGray: begin
            new_color   = {gray, gray, gray, stored_color[7:0]};
            writes_back = 1'b1;
         end
         default: begin
            new_color   = stored_color;
            writes_back = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/tiled_rgba8_texture_pixel_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pixel engine over a 64x64 RGBA8 texture held in 4x4 tiles. Each request
// writes, reads, inverts (RGB, alpha kept) or greys one pixel; the response
// carries the resulting colour, the tiled byte offset of its alpha byte, and
// a range error flag (colour and offset zero, memory untouched) when the pixel
// lies outside the configured width (low two bits ignored) or height. The four
// bytes of a pixel form one 32-bit word of a 4096-word RAM with one read port,
// one write port and a registered read; each request reads its word on transfer,
// and the modified word is written back as it moves into the response register,
// with the last write forwarded to a read of the same word issued on that edge.
// Sustained rate is one request per cycle while rsp_stall is low. A request
// passes the RAM read stage and then the response register before its response
// can transfer; a held response stalls the input once both stages are full.
// Stored pixels are undefined until written. CSR writes (0: width, 1: height,
// other indices ignored) are to be made only while the engine is idle.

module tiled_rgba8_texture_pixel_engine (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_func,
   input  wire logic [tpe_pkg::CoordWidth-1:0]       req_pixel_x,
   input  wire logic [tpe_pkg::CoordWidth-1:0]       req_pixel_y,
   input  wire logic [tpe_pkg::ColorWidth-1:0]       req_write_color,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [tpe_pkg::ColorWidth-1:0]       rsp_result_color,
   output logic      [tpe_pkg::OffsetWidth-1:0]      rsp_byte_offset,
   output logic                                      rsp_range_error,

   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [tpe_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [tpe_pkg::DimWidth-1:0]         csr_wdata
);

   logic [tpe_pkg::DimWidth-1:0]   width_ff;
   logic [tpe_pkg::DimWidth-1:0]   width_in;
   logic [tpe_pkg::DimWidth-1:0]   height_ff;
   logic [tpe_pkg::DimWidth-1:0]   height_in;

   tpe_pkg::addr_type              req_addr;
   logic                           req_xfer;

   logic                           s1_valid_ff;
   logic                           s1_valid_in;
   logic [1:0]                     s1_func_ff;
   logic [tpe_pkg::ColorWidth-1:0] s1_color_ff;
   tpe_pkg::addr_type              s1_addr_ff;
   logic                           s1_adv;

   logic [tpe_pkg::ColorWidth-1:0] stored_color;
   logic [tpe_pkg::ColorWidth-1:0] new_color;
   logic                           writes_back;
   logic                           wr_en;

   logic                              out_valid_ff;
   logic                              out_valid_in;
   logic [tpe_pkg::ColorWidth-1:0]    out_color_ff;
   logic [tpe_pkg::OffsetWidth-1:0]   out_offset_ff;
   logic                              out_error_ff;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tpe_pkg::CsrImageWidth:  width_in  = csr_wdata;
            tpe_pkg::CsrImageHeight: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   tpe_addr u_addr (
      .pixel_x      (req_pixel_x),
      .pixel_y      (req_pixel_y),
      .image_width  (width_ff),
      .image_height (height_ff),
      .addr         (req_addr)
   );

   always_comb begin
      s1_adv      = !out_valid_ff || !rsp_stall;
      req_stall   = s1_valid_ff && !s1_adv;
      req_xfer    = req_valid && !req_stall;
      s1_valid_in = req_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_adv ? s1_valid_ff : out_valid_ff;
      wr_en       = s1_valid_ff && s1_adv && s1_addr_ff.in_range && writes_back;
   end

   tpe_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_xfer),
      .rd_addr (req_addr.word_addr),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff.word_addr),
      .wr_data (new_color),
      .rd_data (stored_color)
   );

   tpe_modify u_modify (
      .func         (s1_func_ff),
      .write_color  (s1_color_ff),
      .stored_color (stored_color),
      .new_color    (new_color),
      .writes_back  (writes_back)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= tpe_pkg::DimReset;
         height_ff    <= tpe_pkg::DimReset;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_func_ff  <= req_func;
         s1_color_ff <= req_write_color;
         s1_addr_ff  <= req_addr;
      end
      if (s1_valid_ff && s1_adv) begin
         out_color_ff  <= s1_addr_ff.in_range ? new_color : '0;
         out_offset_ff <= s1_addr_ff.offset;
         out_error_ff  <= !s1_addr_ff.in_range;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_color = out_color_ff;
   assign rsp_byte_offset  = out_offset_ff;
   assign rsp_range_error  = out_error_ff;

endmodule

`default_nettype wire
